### hdl/sclc_pkg.sv
// ----------------------------------------------------------------------------
// sclc_pkg
// Shared widths, codes, the queued operation word and size-class functions
// for the size-class free-list cache.
// ----------------------------------------------------------------------------
package sclc_pkg;

  localparam int FUNC_W    = 2;
  localparam int CLASS_W   = 6;
  localparam int SIZE_W    = 32;
  localparam int HANDLE_W  = 12;
  localparam int STATUS_W  = 3;
  localparam int REFILL_W  = 13;
  localparam int KIND_W    = 2;

  localparam int NUM_CLASSES_DEF = 64;
  localparam int NUM_BLOCKS_DEF  = 4096;
  localparam int VALID_CLASSES   = 56;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [FUNC_W-1:0] F_POP        = 2'd0;
  localparam logic [FUNC_W-1:0] F_PUSH_CLASS = 2'd1;
  localparam logic [FUNC_W-1:0] F_PUSH_SIZE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_POPPED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HEAP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD    = 3'd4;

  localparam logic [KIND_W-1:0] K_POP  = 2'd0;
  localparam logic [KIND_W-1:0] K_PUSH = 2'd1;
  localparam logic [KIND_W-1:0] K_HEAP = 2'd2;
  localparam logic [KIND_W-1:0] K_BAD  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                bank;
    logic [CLASS_W-1:0]  cls;
    logic [HANDLE_W-1:0] handle;
    logic [REFILL_W-1:0] refill;
  } op_t;

  // b is size minus one, size in 1..4095
  function automatic logic [CLASS_W-1:0] size_to_class(input logic [HANDLE_W-1:0] b);
    logic [CLASS_W-1:0] c;
    if (b < 12'h080) begin
      c = CLASS_W'(b >> 3);
    end else if (b < 12'h100) begin
      c = CLASS_W'(b >> 4) + 6'd8;
    end else if (b < 12'h200) begin
      c = CLASS_W'(b >> 5) + 6'd16;
    end else if (b < 12'h400) begin
      c = CLASS_W'(b >> 6) + 6'd24;
    end else if (b < 12'h800) begin
      c = CLASS_W'(b >> 7) + 6'd32;
    end else begin
      c = CLASS_W'(b >> 8) + 6'd40;
    end
    return c;
  endfunction

  function automatic logic [REFILL_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    logic [REFILL_W-1:0] n;
    logic [REFILL_W-1:0] r;
    n = REFILL_W'(c) + 13'd1;
    if (n <= 13'd16) begin
      r = n << 3;
    end else if (n <= 13'd24) begin
      r = (n - 13'd8) << 4;
    end else if (n <= 13'd32) begin
      r = (n - 13'd16) << 5;
    end else if (n <= 13'd40) begin
      r = (n - 13'd24) << 6;
    end else if (n <= 13'd48) begin
      r = (n - 13'd32) << 7;
    end else begin
      r = (n - 13'd40) << 8;
    end
    return r;
  endfunction

endpackage

### hdl/sclc_front.sv
// ----------------------------------------------------------------------------
// sclc_front
// Input register and classifier: decodes the command, maps byte sizes to a
// class, screens bad classes and oversize blocks, reduces the handle to a
// link-store index and hands the word to the queue.
// ----------------------------------------------------------------------------
module sclc_front #(
  parameter int NUM_BLOCKS = sclc_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sclc_pkg::FUNC_W-1:0]    func,
  input  logic                           raw_bank,
  input  logic [sclc_pkg::CLASS_W-1:0]   class_index,
  input  logic [sclc_pkg::SIZE_W-1:0]    byte_size,
  input  logic [sclc_pkg::HANDLE_W-1:0]  block_handle,
  input  logic                           q_full,
  output logic                           q_push,
  output sclc_pkg::op_t                  op,
  output logic [$clog2(NUM_BLOCKS)-1:0]  link_idx
);
  import sclc_pkg::*;

  localparam int LW = $clog2(NUM_BLOCKS);

  logic                f_valid;
  logic [FUNC_W-1:0]   f_func;
  logic                f_bank;
  logic [CLASS_W-1:0]  f_cls;
  logic [SIZE_W-1:0]   f_size;
  logic [HANDLE_W-1:0] f_handle;
  logic                accept;
  logic [HANDLE_W-1:0] size_m1;

  assign busy   = f_valid && q_full;
  assign accept = start && !busy;
  assign q_push = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_func   <= func;
      f_bank   <= raw_bank;
      f_cls    <= class_index;
      f_size   <= byte_size;
      f_handle <= block_handle;
    end
  end

  assign size_m1 = f_size[HANDLE_W-1:0] - 12'd1;

  always_comb begin
    op.bank   = f_bank;
    op.handle = f_handle;
    op.cls    = f_cls;
    op.refill = '0;
    op.kind   = K_BAD;
    if (f_func == F_PUSH_SIZE) begin
      if (f_size == '0 || (|f_size[SIZE_W-1:HANDLE_W])) begin
        op.kind = K_HEAP;
        op.cls  = '0;
      end else begin
        op.kind = K_PUSH;
        op.cls  = size_to_class(size_m1);
      end
    end else if (f_cls < CLASS_W'(VALID_CLASSES)) begin
      if (f_func == F_POP) begin
        op.kind   = K_POP;
        op.refill = class_bytes(f_cls);
      end else if (f_func == F_PUSH_CLASS) begin
        op.kind = K_PUSH;
      end
    end
  end

  // handle modulo the link-store depth
  generate
    if (NUM_BLOCKS >= (1 << HANDLE_W)) begin : g_idx_wide
      assign link_idx = LW'(f_handle);
    end else begin : g_idx_mod
      function automatic logic [LW-1:0] reduce(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_W+7:0] r;
        r = (HANDLE_W+8)'(h);
        for (int k = 7; k >= 0; k--) begin
          if (r >= ((HANDLE_W+8)'(NUM_BLOCKS) << k)) begin
            r = r - ((HANDLE_W+8)'(NUM_BLOCKS) << k);
          end
        end
        return r[LW-1:0];
      endfunction
      assign link_idx = reduce(f_handle);
    end
  endgenerate

endmodule

### hdl/sclc_queue.sv
// ----------------------------------------------------------------------------
// sclc_queue
// Short FIFO between the classifier and the list engine.
// ----------------------------------------------------------------------------
module sclc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import sclc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/sclc_back.sv
// ----------------------------------------------------------------------------
// sclc_back
// List engine: head table with per-entry valid flops, link store, and the
// registered result word.
// ----------------------------------------------------------------------------
module sclc_back #(
  parameter int NUM_CLASSES = sclc_pkg::NUM_CLASSES_DEF,
  parameter int NUM_BLOCKS  = sclc_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  sclc_pkg::op_t                  q_op,
  input  logic [$clog2(NUM_BLOCKS)-1:0]  q_idx,
  output logic                           q_pop,
  output logic                           done,
  output logic [sclc_pkg::STATUS_W-1:0]  status,
  output logic [sclc_pkg::HANDLE_W-1:0]  out_block,
  output logic [sclc_pkg::REFILL_W-1:0]  refill_bytes,
  output logic [sclc_pkg::CLASS_W-1:0]   out_class
);
  import sclc_pkg::*;

  localparam int LW    = $clog2(NUM_BLOCKS);
  localparam int HD    = 2 * NUM_CLASSES;
  localparam int HA_W  = $clog2(HD);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;

  logic [HANDLE_W+LW-1:0]  head_mem [HD];
  logic [HANDLE_W+LW:0]    link_mem [NUM_BLOCKS];
  logic [HD-1:0]           head_valid;

  op_t                     cur;
  logic [LW-1:0]           cur_idx;
  logic [HA_W-1:0]         cur_addr;
  logic [HA_W-1:0]         q_addr;
  logic                    hv;
  logic [HANDLE_W-1:0]     hd_blk;
  logic [LW-1:0]           hd_idx;
  logic                    lk_valid;
  logic [HANDLE_W-1:0]     lk_blk;
  logic [LW-1:0]           lk_idx;

  logic                    pop_hit;
  logic                    head_we;
  logic [HANDLE_W+LW-1:0]  head_wd;
  logic                    link_we;
  logic                    res_fire;
  logic [STATUS_W-1:0]     res_status;
  logic [HANDLE_W-1:0]     res_block;
  logic [REFILL_W-1:0]     res_refill;

  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign q_addr  = q_op.bank ? (HA_W'(NUM_CLASSES) + HA_W'(q_op.cls)) : HA_W'(q_op.cls);
  assign pop_hit = (state == S_HEAD) && (cur.kind == K_POP) && hv;
  assign link_we = (state == S_HEAD) && (cur.kind == K_PUSH);
  assign head_we = link_we || (state == S_LINK);
  assign head_wd = (state == S_LINK) ? {lk_blk, lk_idx} : {cur.handle, cur_idx};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        state_next = pop_hit ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_fire = ((state == S_HEAD) && !pop_hit) || (state == S_LINK);

  always_comb begin
    case (cur.kind)
      K_POP:   res_status = (state == S_LINK) ? ST_POPPED : ST_MISS;
      K_PUSH:  res_status = ST_PUSHED;
      K_HEAP:  res_status = ST_HEAP;
      default: res_status = ST_BAD;
    endcase
  end

  assign res_block  = (cur.kind == K_HEAP) ? cur.handle :
                      (state == S_LINK)    ? hd_blk     : '0;
  assign res_refill = ((cur.kind == K_POP) && (state == S_HEAD)) ? cur.refill : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      head_valid <= '0;
    end else begin
      state <= state_next;
      done  <= res_fire;
      if (head_we) begin
        head_valid[cur_addr] <= (state == S_LINK) ? lk_valid : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur              <= q_op;
      cur_idx          <= q_idx;
      cur_addr         <= q_addr;
      hv               <= head_valid[q_addr];
      {hd_blk, hd_idx} <= head_mem[q_addr];
    end
    if (head_we) begin
      head_mem[cur_addr] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cur_idx] <= {hv, hd_blk, hd_idx};
    end
    if (pop_hit) begin
      {lk_valid, lk_blk, lk_idx} <= link_mem[hd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      status       <= res_status;
      out_block    <= res_block;
      refill_bytes <= res_refill;
      out_class    <= cur.cls;
    end
  end

endmodule

### hdl/size_class_free_list_cache.sv
// ----------------------------------------------------------------------------
// size_class_free_list_cache
// Two banks of per-class LIFO free lists: pop, push by class, push by size.
// ----------------------------------------------------------------------------
// Command word: func, raw_bank, class_index, byte_size, block_handle, taken
// on a clock edge with start high and busy low. busy rises only when the
// input register holds a word and the two-entry queue behind it is full.
// Each command gives one result word, shown for exactly one cycle with done
// high: status, out_block, refill_bytes, out_class. Results come in order.
// done comes high once the command has passed the input register, the
// queue, the head-table read and, for a pop that hits, the link-store read,
// plus any wait in the queue; the word is taken at the edge after that.
// The list engine reads the head, writes it on a push or pop hit and gives
// the result before it takes the next command; it sets the sustained rate.
// Reset (rst, synchronous) empties every list at once and drops any queued
// commands. The receiver cannot stall: each result is taken in its cycle.
// ----------------------------------------------------------------------------
module size_class_free_list_cache #(
  parameter int NUM_CLASSES = sclc_pkg::NUM_CLASSES_DEF,
  parameter int NUM_BLOCKS  = sclc_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sclc_pkg::FUNC_W-1:0]    func,
  input  logic                           raw_bank,
  input  logic [sclc_pkg::CLASS_W-1:0]   class_index,
  input  logic [sclc_pkg::SIZE_W-1:0]    byte_size,
  input  logic [sclc_pkg::HANDLE_W-1:0]  block_handle,
  output logic                           done,
  output logic [sclc_pkg::STATUS_W-1:0]  status,
  output logic [sclc_pkg::HANDLE_W-1:0]  out_block,
  output logic [sclc_pkg::REFILL_W-1:0]  refill_bytes,
  output logic [sclc_pkg::CLASS_W-1:0]   out_class
);
  import sclc_pkg::*;

  localparam int LW = $clog2(NUM_BLOCKS);
  localparam int QW = $bits(op_t) + LW;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  op_t           f_op;
  logic [LW-1:0] f_idx;
  logic [QW-1:0] q_rdata;
  op_t           q_op;
  logic [LW-1:0] q_idx;

  assign {q_op, q_idx} = q_rdata;

  sclc_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .raw_bank     (raw_bank),
    .class_index  (class_index),
    .byte_size    (byte_size),
    .block_handle (block_handle),
    .q_full       (q_full),
    .q_push       (q_push),
    .op           (f_op),
    .link_idx     (f_idx)
  );

  sclc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_op, f_idx}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  sclc_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_op         (q_op),
    .q_idx        (q_idx),
    .q_pop        (q_pop),
    .done         (done),
    .status       (status),
    .out_block    (out_block),
    .refill_bytes (refill_bytes),
    .out_class    (out_class)
  );

endmodule

### hdl/sclc_checker.sv
// ----------------------------------------------------------------------------
// sclc_checker
// Port-level checks on the result channel of the free-list cache.
// ----------------------------------------------------------------------------
module sclc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           done,
  input logic [sclc_pkg::STATUS_W-1:0]  status,
  input logic [sclc_pkg::HANDLE_W-1:0]  out_block,
  input logic [sclc_pkg::REFILL_W-1:0]  refill_bytes,
  input logic [sclc_pkg::CLASS_W-1:0]   out_class
);
  import sclc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  a_word_spacing: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result words in adjacent cycles");

  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_MISS) |-> (refill_bytes != '0 && out_block == '0))
    else $error("miss word without refill size");

  a_refill_only_miss: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_MISS) |-> (refill_bytes == '0))
    else $error("refill size outside a miss");

  a_heap_class: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_HEAP) |-> (out_class == '0))
    else $error("heap word with nonzero class");

endmodule

bind size_class_free_list_cache sclc_checker u_sclc_checker (
  .clk          (clk),
  .rst          (rst),
  .done         (done),
  .status       (status),
  .out_block    (out_block),
  .refill_bytes (refill_bytes),
  .out_class    (out_class)
);
